### rtl/core/rpnm_pkg.sv
// Shared types and constants for the ring pair nearest match block.
package rpnm_pkg;

    // Fixed field widths of the stream payload
    localparam int FIELD_W   = 16;
    localparam int BLACK_W   = 8;
    localparam int S_TDATA_W = 4 * FIELD_W;
    localparam int M_TDATA_W = FIELD_W + BLACK_W;
    localparam int S_TUSER_W = 2;

    // tuser bit positions on the input side
    localparam int TUSER_REQ_TYPE = 0;
    localparam int TUSER_RESTART  = 1;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register map (register index)
    localparam int          APB_AW             = 3;
    localparam int          APB_DW             = 32;
    localparam logic        REG_RING_THRESHOLD = 1'b0;
    localparam logic [15:0] RING_THRESHOLD_RST = 16'd80;

    // Saturation value of the white ordinal
    localparam logic [FIELD_W-1:0] WHITE_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;      // store the accepted black ellipse
        logic query;     // latch the accepted white ellipse, start a scan
        logic issue;     // read one table entry into the compare pipeline
        logic out_load;  // move the match into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;  // table is empty
        logic addr_last;   // scan address is the last stored entry
        logic pipe_busy;   // compare pipeline still holds entries
        logic hit;         // best entry found and inside the threshold
        logic out_free;    // output register can take a new result
    } t_dp_sts;

endpackage

### rtl/core/rpnm_ctrl.sv
// Controller state machine for the ring pair nearest match block.
module rpnm_ctrl
    import rpnm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic    i_req_type,
    input  t_dp_sts i_sts,
    output logic    o_s_tready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_state     = i_sts.count_zero ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // a miss retires at once, a hit waits for the output register
                if (!i_sts.hit) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rpnm_dpath.sv
// Datapath: black ellipse table, compare pipeline, best tracker and output register.
module rpnm_dpath
    import rpnm_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_restart,
    input  logic [FIELD_W-1:0] i_center_x,
    input  logic [FIELD_W-1:0] i_center_y,
    input  logic [FIELD_W-1:0] i_axis_major,
    input  logic [FIELD_W-1:0] i_axis_minor,
    input  logic [FIELD_W-1:0] i_ring_threshold,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [FIELD_W-1:0] o_white_index,
    output logic [BLACK_W-1:0] o_black_index,
    output t_dp_sts            o_sts
);

    localparam int SW   = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int DW   = 2 * SW + 1;
    localparam int CMPW = (DW > 2 * FIELD_W) ? DW : 2 * FIELD_W;
    localparam int BXW  = (IW > BLACK_W) ? IW : BLACK_W;

    // Table storage: {minor, major, y, x}
    logic [4*SW-1:0] r_mem [TABLE_DEPTH];

    logic [IW:0]        r_count;
    logic [FIELD_W-1:0] r_white;
    logic [IW-1:0]      r_addr;

    // Latched query
    logic [SW-1:0]      r_qx, r_qy, r_qa, r_qb;
    logic [FIELD_W-1:0] r_ordinal;

    // Pipeline stages
    logic            r_v1, r_v2, r_v3;
    logic [IW-1:0]   r_i1, r_i2, r_i3;
    logic [4*SW-1:0] r_rd;
    logic            r_enc2;
    logic [SW-1:0]   r_dx, r_dy;
    logic [2*SW-1:0] r_dx2, r_dy2;

    // Best tracker
    logic            r_found;
    logic [DW-1:0]   r_best;
    logic [IW-1:0]   r_best_idx;
    logic [2*FIELD_W-1:0] r_thr_sq;

    // Output register
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_white;
    logic [BLACK_W-1:0] r_out_black;

    logic            wr_ok;
    logic [IW-1:0]   wr_addr;
    logic [IW:0]     cnt_m1;
    logic [SW-1:0]   ex, ey, ea, eb;
    logic [DW-1:0]   sum_sq;
    logic [BXW-1:0]  best_ext;
    logic            out_free;

    // Load addressing: restart stores at entry zero, a full table drops the load
    always_comb begin
        wr_ok   = i_restart || (r_count < (IW+1)'(TABLE_DEPTH));
        wr_addr = i_restart ? '0 : r_count[IW-1:0];
        cnt_m1  = r_count - 1'b1;
    end

    // Table write
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_mem[wr_addr] <= {i_axis_minor[SW-1:0], i_axis_major[SW-1:0],
                               i_center_y[SW-1:0], i_center_x[SW-1:0]};
        end
    end

    // Table read, registered
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr];
        r_i1 <= r_addr;
    end

    // Counters and scan address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_white <= '0;
            r_addr  <= '0;
        end else begin
            if (i_cmd.load) begin
                if (i_restart) begin
                    r_count <= (IW+1)'(1);
                    r_white <= '0;
                end else if (wr_ok) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.query) begin
                r_addr <= '0;
                if (r_white != WHITE_MAX) begin
                    r_white <= r_white + 1'b1;
                end
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    // Query latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_qx      <= i_center_x[SW-1:0];
            r_qy      <= i_center_y[SW-1:0];
            r_qa      <= i_axis_major[SW-1:0];
            r_qb      <= i_axis_minor[SW-1:0];
            r_ordinal <= r_white;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_enc2;
        end
    end

    // Stage 2: enclosure test and absolute center offsets
    always_comb begin
        ex = r_rd[SW-1:0];
        ey = r_rd[2*SW-1:SW];
        ea = r_rd[3*SW-1:2*SW];
        eb = r_rd[4*SW-1:3*SW];
    end

    always_ff @(posedge i_clk) begin
        r_i2   <= r_i1;
        r_enc2 <= (r_qa < ea) && (r_qb < eb);
        r_dx   <= (r_qx > ex) ? (r_qx - ex) : (ex - r_qx);
        r_dy   <= (r_qy > ey) ? (r_qy - ey) : (ey - r_qy);
    end

    // Stage 3: squares
    always_ff @(posedge i_clk) begin
        r_i3  <= r_i2;
        r_dx2 <= (2*SW)'(r_dx) * (2*SW)'(r_dx);
        r_dy2 <= (2*SW)'(r_dy) * (2*SW)'(r_dy);
    end

    // Stage 4: sum and keep the nearest, earliest entry wins a tie
    assign sum_sq = DW'(r_dx2) + DW'(r_dy2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.query) begin
            r_found <= 1'b0;
        end else if (r_v3 && (!r_found || (sum_sq < r_best))) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && (!r_found || (sum_sq < r_best))) begin
            r_best     <= sum_sq;
            r_best_idx <= r_i3;
        end
        r_thr_sq <= (2*FIELD_W)'(i_ring_threshold) * (2*FIELD_W)'(i_ring_threshold);
    end

    // Output register
    assign out_free = !r_out_valid || i_m_tready;
    assign best_ext = BXW'(r_best_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_white <= r_ordinal;
            r_out_black <= best_ext[BLACK_W-1:0];
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_white_index = r_out_white;
    assign o_black_index = r_out_black;

    // Status to the controller
    always_comb begin
        o_sts.count_zero = (r_count == '0);
        o_sts.addr_last  = (r_addr == cnt_m1[IW-1:0]);
        o_sts.pipe_busy  = r_v1 || r_v2 || r_v3;
        o_sts.hit        = r_found && (CMPW'(r_best) < CMPW'(r_thr_sq));
        o_sts.out_free   = out_free;
    end

endmodule

### rtl/core/ring_pair_nearest_match.sv
// Ring pair nearest match: pairs white ellipses with the nearest enclosing black ellipse.
//
// Loads store a black ellipse in the table and the input stays ready, so
// loads stream at one per cycle. After a query transfer the input stays
// closed until the verdict: an empty table goes straight to the drain,
// and otherwise the scan covers the stored entries and reads one table entry per
// cycle from the table and feeds a four-stage compare pipeline
// (read, offsets, squares, nearest tracking) which drains before the verdict.
// A match lands in an output register, so the next item is taken while a
// result still waits on the output; a match that finds the output register
// still full holds the input closed until that result is taken.
// ring_threshold sits at byte address 0.
module ring_pair_nearest_match
    import rpnm_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // center_x, center_y, axis_major, axis_minor
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type, restart
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // white_index, black_index
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [FIELD_W-1:0] r_ring_threshold;
    logic               reg_idx;
    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [FIELD_W-1:0] white_index;
    logic [BLACK_W-1:0] black_index;

    // Register access: word index taken from the address
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_threshold <= RING_THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == REG_RING_THRESHOLD)) begin
            r_ring_threshold <= pwdata[FIELD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_RING_THRESHOLD) begin
            prdata = APB_DW'(r_ring_threshold);
        end
    end

    rpnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_req_type (s_axis_tuser[TUSER_REQ_TYPE]),
        .i_sts      (sts),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd)
    );

    rpnm_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_restart        (s_axis_tuser[TUSER_RESTART]),
        .i_center_x       (s_axis_tdata[FIELD_W-1:0]),
        .i_center_y       (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_axis_major     (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
        .i_axis_minor     (s_axis_tdata[4*FIELD_W-1:3*FIELD_W]),
        .i_ring_threshold (r_ring_threshold),
        .i_m_tready       (m_axis_tready),
        .o_m_tvalid       (m_axis_tvalid),
        .o_white_index    (white_index),
        .o_black_index    (black_index),
        .o_sts            (sts)
    );

    assign m_axis_tdata = {black_index, white_index};

endmodule

### rtl/core/rpnm_checker.sv
// Port-level checks for the ring pair nearest match block, with its bind.
module rpnm_checker
    import rpnm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // A query transfer closes the input while its verdict is worked out
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[TUSER_REQ_TYPE] == REQ_QUERY)
        |=> !s_axis_tready)
        else $error("input still ready after a query transfer");

    // Loads never close the input
    a_load_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[TUSER_REQ_TYPE] == REQ_LOAD)
        |=> s_axis_tready)
        else $error("input closed after a load transfer");

    // A new result only comes out of a finished scan
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised without a scan");

endmodule

bind ring_pair_nearest_match rpnm_checker u_rpnm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for ring_pair_nearest_match: predicts ring pairs and checks the result stream.
module tb;
    import rpnm_pkg::*;

    localparam int DEPTH          = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 900;

    // One input item
    typedef struct {
        logic        req_type;
        logic        restart;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] axis_major;
        logic [15:0] axis_minor;
    } t_ellipse;

    // One expected ring pair
    typedef struct {
        logic [15:0] white_index;
        logic [7:0]  black_index;
    } t_ring_pair;

    // Clock and DUT signals; the ones the bench drives are known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [APB_AW-1:0]    paddr         = '0;
    logic [APB_DW-1:0]    pwdata        = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    initial forever #2 i_clk = ~i_clk;

    ring_pair_nearest_match #(
        .TABLE_DEPTH(DEPTH),
        .COORD_WIDTH(16)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Black table, counters and threshold mirror; queue of ring pairs still to come
    class ring_pair_predictor;
        logic [15:0] tab_x [DEPTH];
        logic [15:0] tab_y [DEPTH];
        logic [15:0] tab_a [DEPTH];
        logic [15:0] tab_b [DEPTH];
        int unsigned black_count;
        logic [15:0] white_count;
        logic [15:0] threshold;
        t_ring_pair  pending_pairs [$];
        int unsigned errors;

        function new();
            black_count = 0;
            white_count = '0;
            threshold   = RING_THRESHOLD_RST;
            errors      = 0;
        endfunction

        function void set_threshold(input logic [15:0] value);
            threshold = value;
        endfunction

        // Note an accepted item and queue the pair it produces, if any
        function void take_ellipse(input t_ellipse e);
            bit              found;
            int unsigned     best_idx;
            longint unsigned best_d, d, dx, dy, thr_sq;
            logic [15:0]     ordinal;
            t_ring_pair      p;
            if (e.req_type == REQ_LOAD) begin
                if (e.restart) begin
                    black_count = 0;
                    white_count = '0;
                end
                // full table drops the load
                if (black_count < DEPTH) begin
                    tab_x[black_count] = e.center_x;
                    tab_y[black_count] = e.center_y;
                    tab_a[black_count] = e.axis_major;
                    tab_b[black_count] = e.axis_minor;
                    black_count++;
                end
            end else begin
                ordinal = white_count;
                if (white_count != WHITE_MAX) white_count++;
                found    = 1'b0;
                best_idx = 0;
                best_d   = 0;
                for (int j = 0; j < black_count; j++) begin
                    if (e.axis_major < tab_a[j] && e.axis_minor < tab_b[j]) begin
                        dx = (e.center_x > tab_x[j]) ? e.center_x - tab_x[j]
                                                     : tab_x[j] - e.center_x;
                        dy = (e.center_y > tab_y[j]) ? e.center_y - tab_y[j]
                                                     : tab_y[j] - e.center_y;
                        d  = dx * dx + dy * dy;
                        // strict compare keeps the lowest index on ties
                        if (!found || d < best_d) begin
                            found    = 1'b1;
                            best_d   = d;
                            best_idx = j;
                        end
                    end
                end
                thr_sq = longint'(threshold) * longint'(threshold);
                if (found && best_d < thr_sq) begin
                    p.white_index = ordinal;
                    p.black_index = best_idx[7:0];
                    pending_pairs.insert(pending_pairs.size(), p);
                end
            end
        endfunction

        // Compare one result transfer with the oldest expected pair
        function void check_pair(input logic [M_TDATA_W-1:0] data);
            t_ring_pair p;
            if (pending_pairs.size() == 0) begin
                $error("result with nothing expected: tdata %h", data);
                errors++;
            end else begin
                p = pending_pairs.pop_front();
                if (data[15:0] !== p.white_index) begin
                    $error("white_index: expected %0d, actual %0d", p.white_index, data[15:0]);
                    errors++;
                end
                if (data[23:16] !== p.black_index) begin
                    $error("black_index: expected %0d, actual %0d", p.black_index, data[23:16]);
                    errors++;
                end
            end
        endfunction
    endclass

    ring_pair_predictor ring_pairs = new();

    bit          source_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    int unsigned items_sent  = 0;
    int unsigned stall_left  = 0;
    int unsigned quiet_cycles = 0;

    // Result side: check transfers, stall tready at random
    always @(posedge i_clk) begin
        int unsigned r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) ring_pairs.check_pair(m_axis_tdata);
            if (!sink_stalls) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(9, 79);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog: cycles with work outstanding and no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (s_axis_tvalid || !s_axis_tready
                     || ring_pairs.pending_pairs.size() != 0) begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb NOT OK");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 60);
    endfunction

    function automatic logic [15:0] near(input logic [15:0] c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        else if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // Semi-axis for a white ellipse inside the given one, now and then equal
    function automatic logic [15:0] inner_axis(input logic [15:0] outer);
        if ($urandom_range(0, 9) == 0 || outer == 0) return outer;
        return 16'($urandom_range(0, int'(outer) - 1));
    endfunction

    function automatic logic [15:0] pick_threshold();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        else if (r < 30) return 16'hFFFF;
        else if (r < 45) return 16'd80;
        else if (r < 75) return 16'($urandom_range(1, 2000));
        else return 16'($urandom_range(0, 65535));
    endfunction

    // Input side: one transfer, with an optional gap in front
    task automatic send_ellipse(input logic req, input logic rs, input logic [15:0] cx,
                                input logic [15:0] cy, input logic [15:0] amaj,
                                input logic [15:0] amin);
        int                   gap;
        t_ellipse             e;
        logic [S_TUSER_W-1:0] tuser_bits;
        gap = source_gaps ? pick_gap() : 0;
        e.req_type   = req;
        e.restart    = rs;
        e.center_x   = cx;
        e.center_y   = cy;
        e.axis_major = amaj;
        e.axis_minor = amin;
        tuser_bits                 = '0;
        tuser_bits[TUSER_REQ_TYPE] = req;
        tuser_bits[TUSER_RESTART]  = rs;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {amin, amaj, cy, cx};
        s_axis_tuser  <= tuser_bits;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        ring_pairs.take_ellipse(e);
        items_sent++;
    endtask

    task automatic send_noise();
        send_ellipse(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // Let every result arrive and any silent scan finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (ring_pairs.pending_pairs.size() != 0 || !s_axis_tready) @(posedge i_clk);
        repeat (DEPTH + 16) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * REG_RING_THRESHOLD);
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        ring_pairs.set_threshold(value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(4 * REG_RING_THRESHOLD);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {16'd0, ring_pairs.threshold}) begin
            $error("ring_threshold: expected %0d, actual %0d", ring_pairs.threshold, prdata);
            ring_pairs.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic retune(input logic [15:0] value);
        settle();
        apb_write(value);
        apb_read_check();
    endtask

    // A table of black ellipses around one spot, then white ellipses inside them
    task automatic run_scene(input int n, input int q);
        logic [15:0] sx [300];
        logic [15:0] sy [300];
        logic [15:0] sa [300];
        logic [15:0] sb [300];
        logic [15:0] bx, by;
        int          span, spread, j;
        bit          fresh;
        span = int'(ring_pairs.threshold) + 8;
        if (span > 65535) span = 65535;
        spread = ($urandom_range(0, 3) == 0) ? 65535 : 2 * span + 64;
        if (spread > 65535) spread = 65535;
        bx    = 16'($urandom_range(0, 65535));
        by    = 16'($urandom_range(0, 65535));
        fresh = ($urandom_range(0, 99) < 85);
        for (int i = 0; i < n; i++) begin
            sx[i] = near(bx, spread);
            sy[i] = near(by, spread);
            sa[i] = 16'($urandom_range(0, 65535));
            sb[i] = 16'($urandom_range(0, 65535));
            send_ellipse(REQ_LOAD, fresh && i == 0, sx[i], sy[i], sa[i], sb[i]);
        end
        for (int k = 0; k < q; k++) begin
            j = $urandom_range(0, n - 1);
            send_ellipse(REQ_QUERY, 1'($urandom_range(0, 1)), near(sx[j], span),
                         near(sy[j], span), inner_axis(sa[j]), inner_axis(sb[j]));
        end
    endtask

    initial begin
        int unsigned start, scene, r, n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the threshold
        apb_read_check();

        // Directed part at the reset threshold
        send_ellipse(REQ_QUERY, 1'b0, 16'd100, 16'd100, 16'd10, 16'd10);   // empty table
        send_ellipse(REQ_LOAD, 1'b1, 16'd100, 16'd100, 16'd1000, 16'd1000);
        send_ellipse(REQ_LOAD, 1'b0, 16'd100, 16'd100, 16'd1000, 16'd1000);
        send_ellipse(REQ_QUERY, 1'b0, 16'd100, 16'd100, 16'd10, 16'd10);   // tie, lowest index
        send_ellipse(REQ_QUERY, 1'b0, 16'd100, 16'd100, 16'd1000, 16'd10); // equal axis
        send_ellipse(REQ_QUERY, 1'b0, 16'd180, 16'd100, 16'd10, 16'd10);   // on the threshold
        send_ellipse(REQ_QUERY, 1'b0, 16'd179, 16'd100, 16'd10, 16'd10);   // just inside
        send_ellipse(REQ_QUERY, 1'b1, 16'd100, 16'd140, 16'd999, 16'd999); // restart ignored
        send_ellipse(REQ_LOAD, 1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_ellipse(REQ_QUERY, 1'b0, 16'd0, 16'd0, 16'hFFFE, 16'hFFFE);
        send_ellipse(REQ_LOAD, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_ellipse(REQ_QUERY, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_ellipse(REQ_QUERY, 1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd0);      // far from all
        send_ellipse(REQ_QUERY, 1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);   // nothing encloses

        // widest threshold
        retune(16'hFFFF);
        send_ellipse(REQ_QUERY, 1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_ellipse(REQ_QUERY, 1'b0, 16'h8000, 16'h8000, 16'd5, 16'd5);
        send_ellipse(REQ_LOAD, 1'b1, 16'd0, 16'hFFFF, 16'd0, 16'd0);       // zero axes
        send_ellipse(REQ_QUERY, 1'b0, 16'd0, 16'hFFFF, 16'd0, 16'd0);

        // zero threshold: nothing ever pairs
        retune(16'd0);
        send_ellipse(REQ_LOAD, 1'b1, 16'd500, 16'd500, 16'd300, 16'd300);
        send_ellipse(REQ_QUERY, 1'b0, 16'd500, 16'd500, 16'd1, 16'd1);
        send_ellipse(REQ_QUERY, 1'b0, 16'd501, 16'd500, 16'd1, 16'd1);

        // full table, with loads past the end dropped
        retune(16'd4000);
        run_scene(260, 8);

        // Random scenes with new thresholds now and then
        start = items_sent;
        scene = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (scene % 6 == 0) retune(pick_threshold());
            source_gaps = ($urandom_range(0, 9) != 0);
            sink_stalls = ($urandom_range(0, 9) != 0);
            r = $urandom_range(0, 99);
            if (r < 2) n = $urandom_range(256, 270);
            else if (r < 85) n = $urandom_range(1, 8);
            else n = $urandom_range(9, 40);
            run_scene(n, $urandom_range(1, 8));
            if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 4)) send_noise();
            scene++;
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (ring_pairs.pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 40) @(posedge i_clk);

        if (ring_pairs.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
